FILE: design/signed_int_to_decimal_ascii_unit_defines.svh
// Assertion macros for the signed integer to decimal ASCII unit.
// Expects clk and arst_n in the scope of each use.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

// same-cycle implication
`define SDAI_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sdai check failed");

// next-cycle implication
`define SDAI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sdai check failed");

`endif

FILE: design/sdai_pkg.sv
// Shared types and ASCII constants for the decimal text unit.
// No dependencies.
`timescale 1ns / 1ps

package sdai_pkg;
	localparam int CHAR_W = 7;

	typedef logic [CHAR_W-1:0] char_t;

	localparam char_t ASCII_ZERO  = 7'd48;
	localparam char_t ASCII_NINE  = 7'd57;
	localparam char_t ASCII_MINUS = 7'd45;
endpackage

FILE: design/sdai_front.sv
// Front stage: accept a value, split it into sign and unsigned magnitude.
// Depends on nothing; feeds sdai_fifo.
`timescale 1ns / 1ps

module sdai_front #(
	parameter int IntWidth = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IntWidth-1:0]   value,
	input  logic                  value_valid,
	output logic                  value_ready,
	output logic                  push_valid,
	input  logic                  push_ready,
	output logic [IntWidth:0]     push_data
);
	logic                v_s1;
	logic                neg_s1;
	logic [IntWidth-1:0] mag_s1;
	logic                take;

	assign value_ready = !v_s1 || push_ready;
	assign take        = value_valid && value_ready;
	assign push_valid  = v_s1;
	assign push_data   = {neg_s1, mag_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			neg_s1 <= value[IntWidth-1];
			mag_s1 <= value[IntWidth-1] ? (~value + 1'b1) : value;
		end
	end
endmodule

FILE: design/sdai_fifo.sv
// Two-entry queue between the front stage and the converter.
// No dependencies.
`timescale 1ns / 1ps

module sdai_fifo #(
	parameter int Width = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [Width-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [Width-1:0] pop_data,
	output logic [1:0]       level
);
	logic [Width-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign level      = count_q;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

FILE: design/sdai_back.sv
// Back end: bit-serial double dabble converter, then a character emitter
// with its own output register. Depends on sdai_pkg.
`timescale 1ns / 1ps

module sdai_back #(
	parameter int IntWidth = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  logic [IntWidth:0]   q_data,
	output sdai_pkg::char_t     char_code,
	output logic                last_char,
	output logic                char_valid,
	input  logic                char_ready
);
	import sdai_pkg::*;

	localparam int DIGITS = ((IntWidth - 1) * 3) / 10 + 1;
	localparam int CNT_W  = $clog2(IntWidth);
	localparam int POS_W  = $clog2(DIGITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(IntWidth - 1);

	localparam logic [1:0] CV_IDLE = 2'd0;
	localparam logic [1:0] CV_RUN  = 2'd1;
	localparam logic [1:0] CV_DONE = 2'd2;

	logic [1:0]                cv_state_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [IntWidth-1:0]       shf_q;
	logic [DIGITS-1:0][3:0]    bcd_q;
	logic                      cv_neg_q;
	logic [DIGITS-1:0][3:0]    bcd_adj;
	logic [4*DIGITS-1:0]       adj_flat;
	logic [DIGITS-1:0][3:0]    bcd_step;
	logic [POS_W-1:0]          top_pos;

	logic                      em_busy_q;
	logic                      minus_q;
	logic [DIGITS-1:0][3:0]    dig_q;
	logic [POS_W-1:0]          pos_q;
	logic                      out_valid_q;
	char_t                     char_q;
	logic                      last_q;
	logic                      load;
	logic                      em_adv;

	assign q_ready = (cv_state_q == CV_IDLE);
	assign load    = (cv_state_q == CV_DONE) && !em_busy_q;
	assign em_adv  = em_busy_q && (!out_valid_q || char_ready);

	assign char_valid = out_valid_q;
	assign char_code  = char_q;
	assign last_char  = last_q;

	always_comb begin
		for (int d = 0; d < DIGITS; d++) begin
			bcd_adj[d] = (bcd_q[d] >= 4'd5) ? (bcd_q[d] + 4'd3) : bcd_q[d];
		end
		adj_flat = bcd_adj;
		bcd_step = {adj_flat[4*DIGITS-2:0], shf_q[IntWidth-1]};
	end

	always_comb begin
		top_pos = '0;
		for (int d = 1; d < DIGITS; d++) begin
			if (bcd_q[d] != 4'd0) begin
				top_pos = POS_W'(d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_state_q <= CV_IDLE;
			cnt_q      <= '0;
		end else begin
			unique case (cv_state_q)
				CV_IDLE: begin
					if (q_valid) begin
						cv_state_q <= CV_RUN;
						cnt_q      <= '0;
					end
				end
				CV_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						cv_state_q <= CV_DONE;
					end
				end
				CV_DONE: begin
					if (!em_busy_q) begin
						cv_state_q <= CV_IDLE;
					end
				end
				default: begin
					cv_state_q <= CV_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cv_state_q == CV_IDLE && q_valid) begin
			cv_neg_q <= q_data[IntWidth];
			shf_q    <= q_data[IntWidth-1:0];
			bcd_q    <= '0;
		end else if (cv_state_q == CV_RUN) begin
			shf_q <= {shf_q[IntWidth-2:0], 1'b0};
			bcd_q <= bcd_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_busy_q   <= 1'b0;
			minus_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				em_busy_q <= 1'b1;
				minus_q   <= cv_neg_q;
			end else if (em_adv) begin
				if (minus_q) begin
					minus_q <= 1'b0;
				end else if (pos_q == '0) begin
					em_busy_q <= 1'b0;
				end
			end
			if (em_adv) begin
				out_valid_q <= 1'b1;
			end else if (char_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dig_q <= bcd_q;
			pos_q <= top_pos;
		end else if (em_adv) begin
			if (minus_q) begin
				char_q <= ASCII_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= ASCII_ZERO + {3'b000, dig_q[pos_q]};
				last_q <= (pos_q == '0);
				if (pos_q != '0) begin
					pos_q <= pos_q - 1'b1;
				end
			end
		end
	end
endmodule

FILE: design/signed_int_to_decimal_ascii_unit.sv
// Signed integer to decimal ASCII text: value channel in, one character per beat out.
// Usage:
//   value/value_valid/value_ready take one signed INT_WIDTH-bit integer per beat.
//   char_code/last_char/char_valid/char_ready give its text, most significant
//   character first: '-' for a negative value, then the digits without leading
//   zeros ('0' alone for zero); last_char marks the final character.
//   From an accepted value to char_valid of its first character, the value passes
//   the front register, queue, converter load, INT_WIDTH dabble steps, emitter
//   load and output register. The converter shifts one magnitude bit per cycle;
//   characters leave at one per cycle while char_ready is high, and the next
//   value converts while the characters of the current one are emitted.
//   The most negative value prints in full.
//   Reset clears all valid flags and the queue; no clearing pass is needed.
//   A stalled receiver holds the current character; the emitter, converter,
//   queue and front register then fill in turn before value_ready drops.
// Depends on sdai_pkg, sdai_front, sdai_fifo, sdai_back and the defines header.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_unit_defines.svh"

module signed_int_to_decimal_ascii_unit #(
	parameter int INT_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [INT_WIDTH-1:0] value,
	input  logic                    value_valid,
	output logic                    value_ready,
	output sdai_pkg::char_t         char_code,
	output logic                    last_char,
	output logic                    char_valid,
	input  logic                    char_ready
);
	import sdai_pkg::*;

	logic                   push_valid;
	logic                   push_ready;
	logic [INT_WIDTH:0]     push_data;
	logic                   q_valid;
	logic                   q_ready;
	logic [INT_WIDTH:0]     q_data;
	logic [1:0]             q_level;

	sdai_front #(
		.IntWidth (INT_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.value_valid (value_valid),
		.value_ready (value_ready),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	sdai_fifo #(
		.Width (INT_WIDTH + 1)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data),
		.level      (q_level)
	);

	sdai_back #(
		.IntWidth (INT_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_data     (q_data),
		.char_code  (char_code),
		.last_char  (last_char),
		.char_valid (char_valid),
		.char_ready (char_ready)
	);

	`SDAI_ASSERT_IMPL(a_char_range, char_valid,
		(char_code == ASCII_MINUS) || ((char_code >= ASCII_ZERO) && (char_code <= ASCII_NINE)))
	`SDAI_ASSERT_IMPL(a_minus_not_last, char_valid && (char_code == ASCII_MINUS), !last_char)
	`SDAI_ASSERT_NEXT(a_digit_after_minus,
		char_valid && char_ready && (char_code == ASCII_MINUS),
		char_valid && (char_code != ASCII_MINUS))
	`SDAI_ASSERT_IMPL(a_queue_bound, 1'b1, q_level != 2'd3)
endmodule
